FILE: src/cpc_pkg.sv
// ----------------------------------------------------------------------------
// Cosine palette package
// Shared widths, register codes, reset values and the quarter-wave cosine table.
// ----------------------------------------------------------------------------
package cpc_pkg;

	localparam int COEF_FRAC_BITS = 12;
	localparam int COS_TABLE_BITS = 10;

	localparam int POS_FRAC_BITS = 16;
	localparam int POS_W         = POS_FRAC_BITS + 1;
	localparam int FIELD_W       = 16;
	localparam int NUM_CH        = 3;
	localparam int REG_W         = FIELD_W * NUM_CH;
	localparam int INDEX_W       = 2;
	localparam int COLOR_FRAC    = 12;
	localparam int COLOR_W       = COLOR_FRAC + 1;

	localparam int COS_FRAC_BITS = 14;
	localparam int COS_W         = COS_FRAC_BITS + 1;
	localparam int QUARTER       = 1 << COS_TABLE_BITS;
	localparam int ADDR_W        = COS_TABLE_BITS + 1;
	localparam int IDX_W         = COS_TABLE_BITS + 2;

	localparam int TURN_W        = COEF_FRAC_BITS + POS_FRAC_BITS;
	localparam int DROP          = TURN_W - IDX_W;
	localparam int FPROD_W       = FIELD_W + POS_W + 1;
	localparam int CPROD_W       = 2 * FIELD_W;
	localparam int SUM_W         = CPROD_W + 1;
	localparam int ACC_FRAC      = COEF_FRAC_BITS + COS_FRAC_BITS;

	localparam logic [INDEX_W-1:0] REG_BASE      = 2'd0;
	localparam logic [INDEX_W-1:0] REG_AMPLITUDE = 2'd1;
	localparam logic [INDEX_W-1:0] REG_FREQUENCY = 2'd2;
	localparam logic [INDEX_W-1:0] REG_PHASE     = 2'd3;

	localparam logic [REG_W-1:0] BASE_RESET      = 48'h0800_0800_0800;
	localparam logic [REG_W-1:0] AMPLITUDE_RESET = 48'h0800_0800_0800;
	localparam logic [REG_W-1:0] FREQUENCY_RESET = 48'h1000_1000_1000;
	localparam logic [REG_W-1:0] PHASE_RESET     = 48'h0AB8_0548_0000;

	localparam longint          Q30_ONE     = 64'sd1 << 30;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	typedef logic [COS_W-1:0] cos_table_t [0:QUARTER];

	// restoring quotient of two nonnegative operands
	function automatic longint unsigned const_udiv(longint unsigned num,
			longint unsigned den);
		longint unsigned quo;
		longint unsigned rem;
		int              b;
		quo = '0;
		rem = '0;
		for (b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= den) begin
				rem    = rem - den;
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	function automatic cos_table_t build_cos_table();
		cos_table_t      tbl;
		longint unsigned xu;
		longint unsigned x2u;
		longint          x2;
		longint          r;
		longint          m;
		int              k;
		int              n;
		for (k = 0; k <= QUARTER; k++) begin
			xu  = (HALF_PI_Q30 * 64'(k)) >> COS_TABLE_BITS;
			x2u = (xu * xu) >> 30;
			x2  = longint'(x2u);
			r   = Q30_ONE;
			for (n = 9; n >= 1; n--) begin
				m = longint'((2 * n - 1) * (2 * n));
				r = Q30_ONE - longint'(const_udiv($unsigned(x2 * r), $unsigned(m * Q30_ONE)));
			end
			if (r < 0) r = 0;
			if (r > Q30_ONE) r = Q30_ONE;
			tbl[k] = COS_W'((r + (64'sd1 << 15)) >>> 16);
		end
		return tbl;
	endfunction

	localparam cos_table_t COS_TABLE = build_cos_table();

endpackage

FILE: src/cosine_palette_color.sv
// ----------------------------------------------------------------------------
// Cosine palette color
// Maps a palette position to clamped RGB through base + amp * cos(freq*t + phase).
// ----------------------------------------------------------------------------
// An accepted position passes the product, index, table, cosine and color
// registers in order. Throughput: one word per cycle while out_stall is low;
// each of the five stages holds one word and moves on once the next has room.
// Reset: pipeline valids clear, coefficient registers return to their
// default palette; the cosine table is constant and needs no fill.
module cosine_palette_color (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [cpc_pkg::INDEX_W-1:0]       wr_index,
	input  logic [cpc_pkg::REG_W-1:0]         wr_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [cpc_pkg::POS_W-1:0]         position,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [cpc_pkg::COLOR_W-1:0]       red,
	output logic [cpc_pkg::COLOR_W-1:0]       green,
	output logic [cpc_pkg::COLOR_W-1:0]       blue
);

	logic [cpc_pkg::REG_W-1:0] base_q;
	logic [cpc_pkg::REG_W-1:0] amplitude_q;
	logic [cpc_pkg::REG_W-1:0] frequency_q;
	logic [cpc_pkg::REG_W-1:0] phase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= cpc_pkg::BASE_RESET;
			amplitude_q <= cpc_pkg::AMPLITUDE_RESET;
			frequency_q <= cpc_pkg::FREQUENCY_RESET;
			phase_q     <= cpc_pkg::PHASE_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				cpc_pkg::REG_BASE:      base_q      <= wr_data;
				cpc_pkg::REG_AMPLITUDE: amplitude_q <= wr_data;
				cpc_pkg::REG_FREQUENCY: frequency_q <= wr_data;
				cpc_pkg::REG_PHASE:     phase_q     <= wr_data;
				default:                base_q      <= base_q;
			endcase
		end
	end

	logic       v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [5:1] stage_ready;

	always_comb begin
		stage_ready[5] = !v_s5 || !out_stall;
		stage_ready[4] = !v_s4 || stage_ready[5];
		stage_ready[3] = !v_s3 || stage_ready[4];
		stage_ready[2] = !v_s2 || stage_ready[3];
		stage_ready[1] = !v_s1 || stage_ready[2];
	end

	assign in_stall = !stage_ready[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (stage_ready[1]) v_s1 <= in_valid;
			if (stage_ready[2]) v_s2 <= v_s1;
			if (stage_ready[3]) v_s3 <= v_s2;
			if (stage_ready[4]) v_s4 <= v_s3;
			if (stage_ready[5]) v_s5 <= v_s4;
		end
	end

	logic [cpc_pkg::COLOR_W-1:0] color_s5 [cpc_pkg::NUM_CH];

	for (genvar ch = 0; ch < cpc_pkg::NUM_CH; ch++) begin : g_lane
		logic signed [cpc_pkg::FIELD_W-1:0]  freq;
		logic signed [cpc_pkg::FIELD_W-1:0]  ph;
		logic signed [cpc_pkg::FIELD_W-1:0]  base;
		logic signed [cpc_pkg::FIELD_W-1:0]  amp;
		logic signed [cpc_pkg::FPROD_W-1:0]  fprod;
		logic [cpc_pkg::TURN_W-1:0]          turn;
		logic [cpc_pkg::IDX_W-1:0]           idx;
		logic [cpc_pkg::ADDR_W-1:0]          k_ext;
		logic [cpc_pkg::ADDR_W-1:0]          addr;
		logic signed [cpc_pkg::FIELD_W-1:0]  cos_val;
		logic signed [cpc_pkg::SUM_W-1:0]    acc;
		logic signed [cpc_pkg::SUM_W-1:0]    rounded;
		logic [cpc_pkg::COLOR_W-1:0]         color;

		logic [cpc_pkg::TURN_W-1:0]          fprod_s1;
		logic [cpc_pkg::IDX_W-1:0]           idx_s2;
		logic [cpc_pkg::COS_W-1:0]           tbl_s3;
		logic                                neg_s3;
		logic signed [cpc_pkg::CPROD_W-1:0]  cprod_s4;

		localparam logic signed [cpc_pkg::SUM_W-1:0] CLAMP_ONE =
			cpc_pkg::SUM_W'(1) << cpc_pkg::ACC_FRAC;
		localparam logic signed [cpc_pkg::SUM_W-1:0] ROUND_HALF =
			cpc_pkg::SUM_W'(1) << (cpc_pkg::ACC_FRAC - cpc_pkg::COLOR_FRAC - 1);
		localparam logic [cpc_pkg::TURN_W-1:0] TURN_HALF =
			cpc_pkg::TURN_W'(1) << (cpc_pkg::DROP - 1);

		assign freq = $signed(frequency_q[cpc_pkg::FIELD_W*ch +: cpc_pkg::FIELD_W]);
		assign ph   = $signed(phase_q[cpc_pkg::FIELD_W*ch +: cpc_pkg::FIELD_W]);
		assign base = $signed(base_q[cpc_pkg::FIELD_W*ch +: cpc_pkg::FIELD_W]);
		assign amp  = $signed(amplitude_q[cpc_pkg::FIELD_W*ch +: cpc_pkg::FIELD_W]);

		always_comb begin
			fprod = cpc_pkg::FPROD_W'(freq) * $signed({1'b0, position});
			turn  = fprod_s1 + {ph[cpc_pkg::COEF_FRAC_BITS-1:0],
				{cpc_pkg::POS_FRAC_BITS{1'b0}}} + TURN_HALF;
			idx   = turn[cpc_pkg::TURN_W-1:cpc_pkg::DROP];
			k_ext = {1'b0, idx_s2[cpc_pkg::COS_TABLE_BITS-1:0]};
			addr  = idx_s2[cpc_pkg::COS_TABLE_BITS]
				? cpc_pkg::ADDR_W'(cpc_pkg::QUARTER) - k_ext : k_ext;
			cos_val = neg_s3 ? -$signed({1'b0, tbl_s3}) : $signed({1'b0, tbl_s3});
			acc     = (cpc_pkg::SUM_W'(base) <<< cpc_pkg::COS_FRAC_BITS)
				+ cpc_pkg::SUM_W'(cprod_s4);
			rounded = (acc + ROUND_HALF) >>> (cpc_pkg::ACC_FRAC - cpc_pkg::COLOR_FRAC);
			if (acc <= 0) begin
				color = '0;
			end else if (acc >= CLAMP_ONE) begin
				color = cpc_pkg::COLOR_W'(1) << cpc_pkg::COLOR_FRAC;
			end else begin
				color = rounded[cpc_pkg::COLOR_W-1:0];
			end
		end

		always_ff @(posedge clk) begin
			if (stage_ready[1] && in_valid) fprod_s1 <= fprod[cpc_pkg::TURN_W-1:0];
			if (stage_ready[2]) idx_s2 <= idx;
			if (stage_ready[3]) begin
				tbl_s3 <= cpc_pkg::COS_TABLE[addr];
				neg_s3 <= idx_s2[cpc_pkg::COS_TABLE_BITS+1] ^ idx_s2[cpc_pkg::COS_TABLE_BITS];
			end
			if (stage_ready[4]) cprod_s4 <= amp * cos_val;
			if (stage_ready[5]) color_s5[ch] <= color;
		end
	end

	assign out_valid = v_s5;
	assign red       = color_s5[0];
	assign green     = color_s5[1];
	assign blue      = color_s5[2];

`ifndef SYNTHESIS
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && out_stall))
		else $error("input stalled with room in the pipeline");

	a_color_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (red <= 13'd4096 && green <= 13'd4096 && blue <= 13'd4096))
		else $error("color above full scale");

	a_word_arrives: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && stage_ready[5]) |=> out_valid)
		else $error("word lost between last stages");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !v_s4) |=> !out_valid)
		else $error("word repeated on output");
`endif

endmodule
